// ----- rtl/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int NUM_PATHS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 32;

    // Width of the pass-bit field in an input item.
    localparam int PATH_FIELD_BITS = 8;

    // Stream payload widths.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_W      = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Register select, taken from paddr[2].
    localparam logic REG_NUM_PATHS = 1'b0;

    // Item kinds carried in tuser.
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Rows of the summary bank.
    localparam int SUM_TOTAL = 0;
    localparam int SUM_ANY   = 1;
    localparam int SUM_ONE   = 2;
    localparam int SUM_ROWS  = 3;

    typedef enum logic [1:0] {
        BANK_SUMMARY = 2'd0,
        BANK_PASS    = 2'd1,
        BANK_EXCL    = 2'd2,
        BANK_PAIR    = 2'd3
    } t_bank;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RECORD,
        ST_RESP
    } t_state;

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_TOTAL,
        WS_ANY,
        WS_ONE,
        WS_EXCL,
        WS_PASS,
        WS_PAIR
    } t_walk_step;

endpackage

`default_nettype wire

// ----- rtl/tcc_ram.sv -----
`default_nettype none

module tcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 83,
    parameter int AW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port; the read data is registered and held while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/tcc_walk.sv -----
`default_nettype none

module tcc_walk #(
    parameter int NUM_PATHS = 8,
    parameter int AW        = 7,
    localparam int LIM = (NUM_PATHS < tcc_pkg::PATH_FIELD_BITS) ?
                         NUM_PATHS : tcc_pkg::PATH_FIELD_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [LIM-1:0] i_pass,
    output logic                o_rd_en,
    output logic      [AW-1:0]  o_rd_addr,
    output logic                o_last
);

    localparam int IW        = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int PASS_BASE = tcc_pkg::SUM_ROWS;
    localparam int EXCL_BASE = tcc_pkg::SUM_ROWS + NUM_PATHS;
    localparam int PAIR_BASE = tcc_pkg::SUM_ROWS + 2 * NUM_PATHS;

    tcc_pkg::t_walk_step r_step, n_step;
    logic [LIM-1:0]      r_pass;
    logic [IW-1:0]       r_i, n_i;
    logic [IW-1:0]       r_j, n_j;
    logic [3:0]          pass_cnt;
    logic [IW-1:0]       last_idx;

    // Number of passing paths and the index of the highest one.
    always_comb begin
        pass_cnt = 4'd0;
        last_idx = '0;
        for (int k = 0; k < LIM; k++) begin
            if (r_pass[k]) begin
                pass_cnt = pass_cnt + 4'd1;
                last_idx = IW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tcc_pkg::WS_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == tcc_pkg::WS_IDLE && i_start) begin
            r_pass <= i_pass;
        end
        r_i <= n_i;
        r_j <= n_j;
    end

    // One counter slot per cycle: summary, exclusive, then per path its pass
    // counter followed by its row of pair counters.
    always_comb begin
        n_step    = r_step;
        n_i       = r_i;
        n_j       = r_j;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_last    = 1'b0;
        unique case (r_step)
            tcc_pkg::WS_IDLE: begin
                if (i_start) begin
                    n_step = tcc_pkg::WS_TOTAL;
                end
            end
            tcc_pkg::WS_TOTAL: begin
                o_rd_en   = 1'b1;
                o_rd_addr = AW'(tcc_pkg::SUM_TOTAL);
                n_step    = tcc_pkg::WS_ANY;
            end
            tcc_pkg::WS_ANY: begin
                o_rd_en   = |r_pass;
                o_rd_addr = AW'(tcc_pkg::SUM_ANY);
                n_step    = tcc_pkg::WS_ONE;
            end
            tcc_pkg::WS_ONE: begin
                o_rd_en   = (pass_cnt == 4'd1);
                o_rd_addr = AW'(tcc_pkg::SUM_ONE);
                n_step    = tcc_pkg::WS_EXCL;
            end
            tcc_pkg::WS_EXCL: begin
                o_rd_en   = (pass_cnt == 4'd1);
                o_rd_addr = AW'(EXCL_BASE + int'(last_idx));
                n_i       = '0;
                n_step    = tcc_pkg::WS_PASS;
            end
            tcc_pkg::WS_PASS: begin
                o_rd_en   = r_pass[r_i];
                o_rd_addr = AW'(PASS_BASE + int'(r_i));
                n_j       = '0;
                n_step    = tcc_pkg::WS_PAIR;
            end
            tcc_pkg::WS_PAIR: begin
                o_rd_en   = r_pass[r_i] && r_pass[r_j];
                o_rd_addr = AW'(PAIR_BASE + int'(r_i) * NUM_PATHS + int'(r_j));
                if (r_j == IW'(LIM - 1)) begin
                    if (r_i == IW'(LIM - 1)) begin
                        o_last = 1'b1;
                        n_step = tcc_pkg::WS_IDLE;
                    end else begin
                        n_i    = r_i + IW'(1);
                        n_step = tcc_pkg::WS_PASS;
                    end
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            default: begin
                n_step = tcc_pkg::WS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/trigger_coincidence_counters.sv -----
`default_nettype none

// Saturating coincidence counters for up to NUM_PATHS trigger paths, held in one
// single-port-read, single-port-write memory of 3 + 2*NUM_PATHS + NUM_PATHS^2
// entries (summary, per-path pass, per-path exclusive, then the pair matrix row
// by row). A record item is walked through the memory one counter slot per cycle,
// read-increment-write, over the first L paths, where L is the smaller of
// NUM_PATHS and 8; the next item then also waits while the write-back of the last
// pair counter, if it was bumped, is still landing. A read item holds the block
// until its result is loaded into the output register, which waits while the
// result side stalls. After reset the block clears the memory one entry per cycle
// before it accepts its first item; configuration writes are taken throughout.
module trigger_coincidence_counters #(
    parameter int NUM_PATHS   = tcc_pkg::NUM_PATHS_DEF,
    parameter int COUNT_WIDTH = tcc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input items.
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [7:0] path_bits, [9:8] counter_bank, [12:10] row, [15:13] column
    input  wire logic [tcc_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [0] operation
    input  wire logic                            i_s_tuser,
    // Result items.
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [31:0] count_value
    output logic      [tcc_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // [0] address_ok
    output logic                                 o_m_tuser,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int LIM = (NUM_PATHS < tcc_pkg::PATH_FIELD_BITS) ?
                         NUM_PATHS : tcc_pkg::PATH_FIELD_BITS;
    localparam int DEPTH     = tcc_pkg::SUM_ROWS + 2 * NUM_PATHS + NUM_PATHS * NUM_PATHS;
    localparam int AW        = $clog2(DEPTH);
    localparam int PASS_BASE = tcc_pkg::SUM_ROWS;
    localparam int EXCL_BASE = tcc_pkg::SUM_ROWS + NUM_PATHS;
    localparam int PAIR_BASE = tcc_pkg::SUM_ROWS + 2 * NUM_PATHS;

    tcc_pkg::t_state              r_state, n_state;
    logic [tcc_pkg::CFG_W-1:0]    r_cfg;
    logic [AW-1:0]                r_clr_addr;
    logic                         r_wb_en;
    logic [AW-1:0]                r_wb_addr;
    logic                         r_rd_ok;
    logic                         r_out_valid;
    logic [tcc_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                         r_out_ok;

    logic                         cfg_wr;
    logic                         in_op;
    logic [7:0]                   in_bits;
    tcc_pkg::t_bank               in_bank;
    logic [2:0]                   in_row;
    logic [2:0]                   in_col;
    logic [LIM-1:0]               in_pass;
    logic                         in_accept;
    logic                         rec_start;
    logic                         rd_issue;
    logic                         q_ok;
    logic [AW-1:0]                q_addr;

    logic                         w_rd_en;
    logic [AW-1:0]                w_rd_addr;
    logic                         w_last;

    logic                         ram_rd_en;
    logic [AW-1:0]                ram_rd_addr;
    logic [COUNT_WIDTH-1:0]       ram_rd_data;
    logic                         ram_wr_en;
    logic [AW-1:0]                ram_wr_addr;
    logic [COUNT_WIDTH-1:0]       ram_wr_data;
    logic [COUNT_WIDTH-1:0]       bumped;
    logic [63:0]                  rd_wide;
    logic [tcc_pkg::OUT_DATA_W-1:0] rd_sat;
    logic                         clr_done;
    logic                         out_free;
    logic                         out_load;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tcc_pkg::REG_NUM_PATHS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tcc_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            r_cfg <= pwdata[tcc_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tcc_pkg::REG_NUM_PATHS) begin
            prdata = tcc_pkg::APB_DATA_W'(r_cfg);
        end
    end

    // Input item unpacking.
    assign in_op   = i_s_tuser;
    assign in_bits = i_s_tdata[7:0];
    assign in_bank = tcc_pkg::t_bank'(i_s_tdata[9:8]);
    assign in_row  = i_s_tdata[12:10];
    assign in_col  = i_s_tdata[15:13];

    // A new item waits while the last write-back of a walk is still landing,
    // so that a read never sees a counter before its final bump.
    assign o_s_tready = (r_state == tcc_pkg::ST_IDLE) && !r_wb_en;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign rec_start  = in_accept && (in_op == tcc_pkg::OP_RECORD);
    assign rd_issue   = in_accept && (in_op == tcc_pkg::OP_READ);

    // Pass bits above the configured path count are dropped.
    always_comb begin
        for (int k = 0; k < LIM; k++) begin
            in_pass[k] = in_bits[k] && (k < int'(r_cfg));
        end
    end

    // Read address decode and range check.
    always_comb begin
        q_ok   = 1'b0;
        q_addr = '0;
        case (in_bank)
            tcc_pkg::BANK_SUMMARY: begin
                q_ok   = int'(in_row) < tcc_pkg::SUM_ROWS;
                q_addr = AW'(int'(in_row));
            end
            tcc_pkg::BANK_PASS: begin
                q_ok   = int'(in_row) < NUM_PATHS;
                q_addr = AW'(PASS_BASE + int'(in_row));
            end
            tcc_pkg::BANK_EXCL: begin
                q_ok   = int'(in_row) < NUM_PATHS;
                q_addr = AW'(EXCL_BASE + int'(in_row));
            end
            tcc_pkg::BANK_PAIR: begin
                q_ok   = (int'(in_row) < NUM_PATHS) && (int'(in_col) < NUM_PATHS);
                q_addr = AW'(PAIR_BASE + int'(in_row) * NUM_PATHS + int'(in_col));
            end
            default: begin
                q_ok = 1'b0;
            end
        endcase
    end

    tcc_walk #(
        .NUM_PATHS (NUM_PATHS),
        .AW        (AW)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rec_start),
        .i_pass    (in_pass),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .o_last    (w_last)
    );

    // Read side: counter walk during a record, single lookup for a read item.
    assign ram_rd_en   = rd_issue || w_rd_en;
    assign ram_rd_addr = rd_issue ? q_addr : w_rd_addr;

    // Saturating increment of the counter read in the previous cycle.
    assign bumped = (&ram_rd_data) ? ram_rd_data : (ram_rd_data + COUNT_WIDTH'(1));

    always_comb begin
        if (r_state == tcc_pkg::ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = r_wb_en;
            ram_wr_addr = r_wb_addr;
            ram_wr_data = bumped;
        end
    end

    tcc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

    // Write-back slot follows each walk read in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_en <= 1'b0;
        end else begin
            r_wb_en <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= w_rd_addr;
        if (rd_issue) begin
            r_rd_ok <= q_ok;
        end
    end

    // Clearing pass after reset.
    assign clr_done = (r_clr_addr == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == tcc_pkg::ST_CLEAR && !clr_done) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Control state machine.
    assign out_free = !r_out_valid || i_m_tready;
    assign out_load = (r_state == tcc_pkg::ST_RESP) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcc_pkg::ST_CLEAR: begin
                if (clr_done) begin
                    n_state = tcc_pkg::ST_IDLE;
                end
            end
            tcc_pkg::ST_IDLE: begin
                if (rec_start) begin
                    n_state = tcc_pkg::ST_RECORD;
                end else if (rd_issue) begin
                    n_state = tcc_pkg::ST_RESP;
                end
            end
            tcc_pkg::ST_RECORD: begin
                if (w_last) begin
                    n_state = tcc_pkg::ST_IDLE;
                end
            end
            tcc_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = tcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcc_pkg::ST_IDLE;
            end
        endcase
    end

    // Counters wider than the result field read as all ones once they exceed it.
    assign rd_wide = 64'(ram_rd_data);
    assign rd_sat  = (|rd_wide[63:32]) ? '1 : rd_wide[31:0];

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_rd_ok ? rd_sat : '0;
            r_out_ok   <= r_rd_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ok;

endmodule

`default_nettype wire

// ----- verif/tcc_count_checker.sv -----
`default_nettype none

module tcc_count_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input item channel
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    // [7:0] path_bits, [9:8] counter_bank, [12:10] row, [15:13] column
    input  wire logic [tcc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [0] operation
    input  wire logic                           i_s_tuser,
    // Result item channel
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    // [31:0] count_value
    input  wire logic [tcc_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // [0] address_ok
    input  wire logic                           i_m_tuser,
    // Configuration port
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [tcc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  wire logic [tcc_pkg::APB_DATA_W-1:0] i_pwdata,
    input  wire logic                           i_pready,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    localparam int PATHS = NUM_PATHS_DEF;
    localparam int CW    = COUNT_WIDTH_DEF;

    typedef logic [CW-1:0] t_count;

    typedef struct packed {
        logic [31:0] count_value;
        logic        address_ok;
    } t_reply;

    // Shadow copy of the counter memory and the path count register.
    t_count           summary_cnt [SUM_ROWS];
    t_count           pass_cnt    [PATHS];
    t_count           excl_cnt    [PATHS];
    t_count           pair_cnt    [PATHS][PATHS];
    logic [CFG_W-1:0] path_count_reg;

    // Replies owed to read items, oldest first.
    t_reply owed_replies [$];
    int     mismatches = 0;
    int     owed_total = 0;

    assign o_pending    = owed_total;
    assign o_fail_count = mismatches;

    // A counter at its top value stays there.
    function automatic t_count sat_inc(t_count c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // The register is clipped to the number of paths and to the width of path_bits.
    function automatic int counted_paths();
        int n;
        n = int'(path_count_reg);
        if (n > PATHS) begin
            n = PATHS;
        end
        if (n > PATH_FIELD_BITS) begin
            n = PATH_FIELD_BITS;
        end
        return n;
    endfunction

    // Books one event into the shadow counters.
    function automatic void tally_event(logic [PATH_FIELD_BITS-1:0] bits);
        int               n;
        int               hits;
        int               lone;
        logic [PATHS-1:0] hit;
        n    = counted_paths();
        hit  = '0;
        hits = 0;
        lone = 0;
        for (int i = 0; i < PATHS; i++) begin
            if (i < n && bits[i]) begin
                hit[i] = 1'b1;
                hits++;
                lone = i;
            end
        end
        summary_cnt[SUM_TOTAL] = sat_inc(summary_cnt[SUM_TOTAL]);
        if (hits == 0) begin
            return;
        end
        summary_cnt[SUM_ANY] = sat_inc(summary_cnt[SUM_ANY]);
        if (hits == 1) begin
            summary_cnt[SUM_ONE] = sat_inc(summary_cnt[SUM_ONE]);
            excl_cnt[lone]       = sat_inc(excl_cnt[lone]);
        end
        for (int i = 0; i < PATHS; i++) begin
            if (hit[i]) begin
                pass_cnt[i] = sat_inc(pass_cnt[i]);
                for (int j = 0; j < PATHS; j++) begin
                    if (hit[j]) begin
                        pair_cnt[i][j] = sat_inc(pair_cnt[i][j]);
                    end
                end
            end
        end
    endfunction

    // Works out the reply to a read item; wide counters are clamped to 32 bits.
    function automatic t_reply lookup_counter(t_bank bank, logic [2:0] row, logic [2:0] col);
        t_reply      r;
        logic [63:0] v;
        v            = '0;
        r.address_ok = 1'b0;
        case (bank)
            BANK_SUMMARY: begin
                if (row < SUM_ROWS) begin
                    v            = 64'(summary_cnt[row]);
                    r.address_ok = 1'b1;
                end
            end
            BANK_PASS, BANK_EXCL: begin
                if (row < PATHS) begin
                    v            = (bank == BANK_PASS) ? 64'(pass_cnt[row]) : 64'(excl_cnt[row]);
                    r.address_ok = 1'b1;
                end
            end
            default: begin
                if (row < PATHS && col < PATHS) begin
                    v            = 64'(pair_cnt[row][col]);
                    r.address_ok = 1'b1;
                end
            end
        endcase
        r.count_value = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

    // Watch all three channels; replies are checked before new items are booked.
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < SUM_ROWS; i++) begin
                summary_cnt[i] = '0;
            end
            for (int i = 0; i < PATHS; i++) begin
                pass_cnt[i] = '0;
                excl_cnt[i] = '0;
                for (int j = 0; j < PATHS; j++) begin
                    pair_cnt[i][j] = '0;
                end
            end
            path_count_reg = CFG_RESET;
            owed_replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (owed_replies.size() == 0) begin
                    $error("unexpected result item: count_value %0d, address_ok %0b",
                           i_m_tdata, i_m_tuser);
                    mismatches++;
                end else begin
                    want = owed_replies.pop_front();
                    if (i_m_tdata !== want.count_value) begin
                        $error("count_value: expected %0d, got %0d", want.count_value, i_m_tdata);
                        mismatches++;
                    end
                    if (i_m_tuser !== want.address_ok) begin
                        $error("address_ok: expected %0b, got %0b", want.address_ok, i_m_tuser);
                        mismatches++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_NUM_PATHS) begin
                path_count_reg = i_pwdata[CFG_W-1:0];
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_READ) begin
                    owed_replies = {owed_replies,
                                    lookup_counter(t_bank'(i_s_tdata[9:8]),
                                                   i_s_tdata[12:10], i_s_tdata[15:13])};
                end else begin
                    tally_event(i_s_tdata[7:0]);
                end
            end
        end
        owed_total = owed_replies.size();
    end

endmodule

`default_nettype wire

// ----- verif/tb_trigger_coincidence_counters.sv -----
`default_nettype none

module tb_trigger_coincidence_counters;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    localparam int HANG_LIMIT  = 2000;
    localparam int SETTLE_WAIT = 100;
    localparam int PHASE_ITEMS = 175;
    localparam int PHASES      = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int quiet_cycles    = 0;
    int stall_left      = 0;
    int ready_free_left = 0;
    int send_free_left  = 0;
    bit calm            = 1'b0;

    always #5 clk = ~clk;

    trigger_coincidence_counters dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    tcc_count_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Result side back-pressure: short stalls, long free stretches, none when calm.
    always @(negedge clk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (ready_free_left > 0) begin
            ready_free_left--;
            m_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    stall_left = $urandom_range(1, 14) - 1;
                    m_tready <= 1'b0;
                end
                1: begin
                    ready_free_left = $urandom_range(20, 120);
                    m_tready <= 1'b1;
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // The run is abandoned when no item moves on either channel for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] item_word(logic [7:0] bits, t_bank bank,
                                                       logic [2:0] row, logic [2:0] col);
        return {col, row, bank, bits};
    endfunction

    // Presents one item and holds it until the block takes it.
    task automatic push_item(logic op, logic [IN_DATA_W-1:0] word);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // Random gaps between items, with stretches of back-to-back items.
    task automatic sender_gap();
        int n;
        if (calm) begin
            return;
        end
        if (send_free_left > 0) begin
            send_free_left--;
        end else if ($urandom_range(0, 49) == 0) begin
            send_free_left = $urandom_range(20, 80);
        end else if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stops sending until every reply is in and a record walk has surely ended.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    // Register write with a setup and an access phase; the upper data bits carry noise.
    task automatic write_path_count(logic [CFG_W-1:0] n);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_NUM_PATHS, 2'b00};
        pwdata  <= ($urandom() & ~32'hF) | 32'(n);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly records and reads with shaped pass patterns.
    task automatic random_item();
        logic [7:0] bits;
        logic       op;
        case ($urandom_range(0, 9))
            0:       bits = 8'h00;
            1, 2:    bits = 8'h01 << $urandom_range(0, 7);
            3:       bits = 8'hFF;
            default: bits = 8'($urandom());
        endcase
        op = ($urandom_range(0, 99) < 55) ? OP_RECORD : OP_READ;
        push_item(op, item_word(bits, t_bank'($urandom_range(0, 3)),
                                3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
    endtask

    initial begin
        logic [CFG_W-1:0] setting;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_RECORD;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Opening items at the reset path count: a read of an empty counter,
        // no pass, all pass, lowest and highest single path, then every bank.
        push_item(OP_READ, item_word(8'hA5, BANK_SUMMARY, 3'd0, 3'd0));
        push_item(OP_RECORD, item_word(8'h00, BANK_PAIR, 3'd7, 3'd7));
        push_item(OP_RECORD, item_word(8'hFF, BANK_SUMMARY, 3'd0, 3'd0));
        push_item(OP_RECORD, item_word(8'h01, BANK_EXCL, 3'd5, 3'd2));
        push_item(OP_RECORD, item_word(8'h80, BANK_PASS, 3'd1, 3'd6));
        push_item(OP_RECORD, item_word(8'h24, BANK_PAIR, 3'd3, 3'd4));
        sender_gap();
        push_item(OP_RECORD, item_word(8'h08, BANK_SUMMARY, 3'd7, 3'd1));
        // Summary rows above the exactly-one row are out of range.
        for (int r = 0; r < 8; r++) begin
            push_item(OP_READ, item_word(8'($urandom()), BANK_SUMMARY, 3'(r), 3'(7 - r)));
        end
        push_item(OP_READ, item_word(8'h00, BANK_PASS, 3'd0, 3'd5));
        push_item(OP_READ, item_word(8'hFF, BANK_PASS, 3'd7, 3'd0));
        push_item(OP_READ, item_word(8'h00, BANK_EXCL, 3'd0, 3'd7));
        push_item(OP_READ, item_word(8'hFF, BANK_EXCL, 3'd7, 3'd3));
        push_item(OP_READ, item_word(8'h00, BANK_PAIR, 3'd0, 3'd0));
        push_item(OP_READ, item_word(8'hFF, BANK_PAIR, 3'd7, 3'd7));
        push_item(OP_READ, item_word(8'h5A, BANK_PAIR, 3'd0, 3'd7));
        push_item(OP_READ, item_word(8'hC3, BANK_PAIR, 3'd7, 3'd0));
        push_item(OP_READ, item_word(8'h3C, BANK_PAIR, 3'd2, 3'd5));

        // Phases at zero, one, above range and full path counts, then random ones.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       setting = 4'd0;
                1:       setting = 4'd1;
                2:       setting = 4'd15;
                3:       setting = 4'd9;
                4:       setting = 4'd8;
                default: setting = 4'($urandom_range(1, 8));
            endcase
            settle();
            write_path_count(setting);
            calm = (p == PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sender_gap();
                random_item();
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
